>>> rtl/scpr_pkg.sv
// Package for the second-chance page replacer.
// Holds the control and status structs shared by the frame cells and the top level.
// No dependencies.
`default_nettype none

package scpr_pkg;

  localparam int unsigned CFG_W         = 5;
  localparam int unsigned FRAME_INDEX_W = 4;

  typedef struct packed {
    logic step;
    logic norm;
    logic commit;
    logic hit;
    logic wr;
  } ctl_t;

  typedef struct packed {
    logic valid;
    logic refd;
    logic dirty;
    logic tok;
    logic match;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/second_chance_page_replacer_unit.sv
// Enhanced second-chance page replacer over a row of frame cells with a travelling hand token.
// Accesses are taken only in S_IDLE; a hit or free-frame fill goes via S_LOOK and S_WRITE,
// and its result is registered as S_WRITE commits. A sweep moves the token one cell per cycle.
// Reset clears all valid, reference and dirty bits and the fill count, puts the hand at frame 0
// and sets the managed frame count to 16 (clamped to FRAMES). Depends on scpr_pkg, scpr_cell.
`default_nettype none

module second_chance_page_replacer_unit #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [scpr_pkg::CFG_W-1:0]        cfg_data_i,      // slots_in_use
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [((PAGE_BITS+7)/8)*8-1:0]    s_axis_tdata,    // page
  input  wire logic [0:0]                        s_axis_tuser,    // is_write
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [((PAGE_BITS+4+7)/8)*8-1:0]       m_axis_tdata,    // frame_index, evicted_page
  output logic [2:0]                             m_axis_tuser     // hit, used_free_frame,
                                                                  // evicted_valid
);

  localparam int unsigned NW     = $clog2(FRAMES + 1);
  localparam int unsigned IW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW     = (NW > scpr_pkg::CFG_W) ? NW : scpr_pkg::CFG_W;
  localparam int unsigned NRST   = (FRAMES < 16) ? FRAMES : 16;
  localparam int unsigned DOUT_W = ((PAGE_BITS + 4 + 7) / 8) * 8;
  localparam int unsigned FIW    = scpr_pkg::FRAME_INDEX_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [NW-1:0]        n_q, n_d;
  logic [NW-1:0]        fill_q, fill_d;
  logic [IW-1:0]        slot_q, slot_d;
  logic                 hit_q, hit_d;
  logic                 fresh_q, fresh_d;
  logic [PAGE_BITS-1:0] key_q;
  logic                 wr_q;

  logic                 m_valid_q, m_valid_d;
  logic                 o_hit_q, o_fresh_q, o_ev_q;
  logic [FIW-1:0]       o_idx_q;
  logic [PAGE_BITS-1:0] o_evpage_q;

  scpr_pkg::ctl_t       ctl;
  scpr_pkg::stat_t      stat   [FRAMES];
  logic [PAGE_BITS-1:0] cpage  [FRAMES];
  logic [FRAMES-1:0]    managed;
  logic [FRAMES-1:0]    sel;
  logic [FRAMES-1:0]    tok_in;

  logic                 hit_any;
  logic [IW-1:0]        hit_idx;
  logic [IW-1:0]        tok_idx;
  logic                 tok_managed;
  logic                 last_tok;
  logic                 chosen;
  logic                 sel_valid;
  logic [PAGE_BITS-1:0] sel_page;
  logic                 out_free;
  logic [CW-1:0]        cfg_ext;
  logic [IW+FIW-1:0]    slot_ext;

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = CW'(cfg_data_i);

  always_comb begin
    n_d = n_q;
    if (cfg_valid_i) begin
      if (cfg_ext == '0) begin
        n_d = NW'(1);
      end else if (cfg_ext > CW'(FRAMES)) begin
        n_d = NW'(FRAMES);
      end else begin
        n_d = NW'(cfg_ext);
      end
    end
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    assign managed[g] = (NW'(g) < n_q);
    assign sel[g]     = (slot_q == IW'(g));

    scpr_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .key_i    (key_q),
      .managed_i(managed[g]),
      .sel_i    (sel[g]),
      .tok_in_i (tok_in[g]),
      .tok_rst_i(g == 0),
      .stat_o   (stat[g]),
      .page_o   (cpage[g])
    );
  end

  always_comb begin
    hit_any     = 1'b0;
    hit_idx     = '0;
    tok_idx     = '0;
    tok_managed = 1'b0;
    last_tok    = 1'b0;
    chosen      = 1'b0;
    sel_valid   = 1'b0;
    sel_page    = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (stat[i].match && !hit_any) begin
        hit_idx = IW'(i);
        hit_any = 1'b1;
      end
      if (stat[i].tok) begin
        tok_idx = tok_idx | IW'(i);
        if (managed[i]) begin
          tok_managed = 1'b1;
        end
        if (NW'(i + 1) == n_q) begin
          last_tok = 1'b1;
        end
        if (!stat[i].refd && !stat[i].dirty) begin
          chosen = 1'b1;
        end
      end
      if (sel[i]) begin
        sel_valid = stat[i].valid;
        sel_page  = cpage[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (ctl.step) begin
        tok_in[i] = (i == 0) ? last_tok : (stat[(i == 0) ? 0 : i - 1].tok && managed[i]);
      end else begin
        tok_in[i] = tok_managed ? stat[i].tok : (i == 0);
      end
    end
  end

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    slot_d     = slot_q;
    hit_d      = hit_q;
    fresh_d    = fresh_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    ctl        = '0;
    ctl.hit    = hit_q;
    ctl.wr     = wr_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        hit_d   = hit_any;
        fresh_d = 1'b0;
        if (hit_any) begin
          slot_d  = hit_idx;
          state_d = S_WRITE;
        end else if (fill_q < n_q) begin
          slot_d  = fill_q[IW-1:0];
          fresh_d = 1'b1;
          fill_d  = fill_q + NW'(1);
          state_d = S_WRITE;
        end else begin
          ctl.norm = 1'b1;
          state_d  = S_SWEEP;
        end
      end
      S_SWEEP: begin
        ctl.step = 1'b1;
        if (chosen) begin
          slot_d  = tok_idx;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          m_valid_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= NW'(NRST);
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign slot_ext = (IW + FIW)'(slot_q);

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    hit_q   <= hit_d;
    fresh_q <= fresh_d;
    if (s_axis_tvalid && s_axis_tready) begin
      key_q <= s_axis_tdata[PAGE_BITS-1:0];
      wr_q  <= s_axis_tuser[0];
    end
    if (ctl.commit) begin
      o_hit_q    <= hit_q;
      o_fresh_q  <= fresh_q;
      o_idx_q    <= slot_ext[FIW-1:0];
      o_ev_q     <= !hit_q && sel_valid;
      o_evpage_q <= (!hit_q && sel_valid) ? sel_page : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = DOUT_W'({o_evpage_q, o_idx_q});
  assign m_axis_tuser  = {o_ev_q, o_fresh_q, o_hit_q};

endmodule

`default_nettype wire

>>> rtl/scpr_cell.sv
// One frame cell of the second-chance page replacer.
// Holds the page, valid, reference and dirty bits and the clock hand token of one frame.
// Depends on scpr_pkg.
`default_nettype none

module scpr_cell #(
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire scpr_pkg::ctl_t       ctl_i,
  input  wire logic [PAGE_BITS-1:0] key_i,
  input  wire logic                 managed_i,
  input  wire logic                 sel_i,
  input  wire logic                 tok_in_i,
  input  wire logic                 tok_rst_i,
  output scpr_pkg::stat_t           stat_o,
  output logic [PAGE_BITS-1:0]      page_o
);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q, valid_d;
  logic                 ref_q, ref_d;
  logic                 dirty_q, dirty_d;
  logic                 tok_q, tok_d;

  always_comb begin
    valid_d = valid_q;
    ref_d   = ref_q;
    dirty_d = dirty_q;
    tok_d   = tok_q;
    if (ctl_i.step || ctl_i.norm) begin
      tok_d = tok_in_i;
    end
    if (ctl_i.step && tok_q) begin
      if (ref_q) begin
        ref_d = 1'b0;
      end else if (dirty_q) begin
        dirty_d = 1'b0;
      end
    end
    if (ctl_i.commit && sel_i) begin
      ref_d = 1'b1;
      if (ctl_i.hit) begin
        dirty_d = dirty_q | ctl_i.wr;
      end else begin
        valid_d = 1'b1;
        dirty_d = ctl_i.wr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      dirty_q <= 1'b0;
      tok_q   <= tok_rst_i;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
      dirty_q <= dirty_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && sel_i && !ctl_i.hit) begin
      page_q <= key_i;
    end
  end

  assign page_o       = page_q;
  assign stat_o.valid = valid_q;
  assign stat_o.refd  = ref_q;
  assign stat_o.dirty = dirty_q;
  assign stat_o.tok   = tok_q;
  assign stat_o.match = valid_q && managed_i && (page_q == key_i);

endmodule

`default_nettype wire

>>> bench/second_chance_page_replacer_unit_tb.sv
// Self-checking testbench for second_chance_page_replacer_unit: directed table, then random phases.
// Each accepted access is run through a behavioral model of the enhanced clock replacer.
// Depends on scpr_pkg and the second_chance_page_replacer_unit RTL.
module second_chance_page_replacer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAMES           = 16;
  localparam int unsigned PAGE_BITS        = 16;
  localparam int unsigned TDATA_IN_W       = ((PAGE_BITS + 7) / 8) * 8;
  localparam int unsigned TDATA_OUT_W      = ((PAGE_BITS + 4 + 7) / 8) * 8;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          DIRECTED_ROWS    = 20;
  localparam int          PHASES           = 12;
  localparam int          PHASE_ACCESSES   = 95;
  localparam int          HOLD_PHASE       = 6;

  typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_e;

  typedef struct packed {
    logic                               hit;
    logic [scpr_pkg::FRAME_INDEX_W-1:0] frame;
    logic                               fresh;
    logic                               ev_valid;
    logic [PAGE_BITS-1:0]               ev_page;
  } access_result_t;

  typedef struct packed {
    row_kind_e                  kind;
    logic [PAGE_BITS-1:0]       page;
    logic                       wr;
    logic [scpr_pkg::CFG_W-1:0] slots;
    logic                       pinned;
    access_result_t             want;
  } row_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [scpr_pkg::CFG_W-1:0] cfg_data_i    = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [TDATA_IN_W-1:0]      s_axis_tdata  = '0;
  logic [0:0]                 s_axis_tuser  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0]     m_axis_tdata;
  logic [2:0]                 m_axis_tuser;

  second_chance_page_replacer_unit #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  logic [PAGE_BITS-1:0]       frame_tag [FRAMES];
  logic                       frame_live [FRAMES];
  logic                       frame_ref [FRAMES];
  logic                       frame_dirty [FRAMES];
  int                         handed_out;
  int                         hand_pos;
  logic [scpr_pkg::CFG_W-1:0] slots_cfg;

  access_result_t pending_results [$];
  access_result_t predicted;
  access_result_t oldest;
  logic           row_pinned = 1'b0;
  access_result_t row_want   = '0;

  int mismatches = 0;
  int accesses   = 0;
  int hits       = 0;
  int evictions  = 0;
  int cfg_writes = 0;

  logic steady_run     = 1'b0;
  logic long_hold_go   = 1'b0;
  logic long_hold_done = 1'b0;
  int   hold_count;

  row_t                       directed_rows [DIRECTED_ROWS];
  logic [scpr_pkg::CFG_W-1:0] phase_slots [PHASES];
  logic [PAGE_BITS-1:0]       page_pool [2 * FRAMES + 2];

  task automatic note_fault(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      note_fault($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, want));
    end
  endtask

  function automatic int clamp_slots(input logic [scpr_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > FRAMES) return FRAMES;
    return int'(v);
  endfunction

  function automatic access_result_t resolve_access(input logic [PAGE_BITS-1:0] page,
                                                    input logic wr);
    access_result_t r;
    int             n;
    int             i;
    int             at;
    logic           chosen;
    r = '0;
    at = 0;
    n = clamp_slots(slots_cfg);
    for (i = 0; i < n && !r.hit; i++) begin
      if (frame_live[i] && frame_tag[i] == page) begin
        frame_ref[i] = 1'b1;
        if (wr) frame_dirty[i] = 1'b1;
        r.frame = i[scpr_pkg::FRAME_INDEX_W-1:0];
        r.hit = 1'b1;
      end
    end
    if (!r.hit) begin
      if (handed_out < n) begin
        at = handed_out;
        handed_out++;
        r.fresh = 1'b1;
      end else begin
        if (hand_pos >= n) hand_pos = 0;
        chosen = 1'b0;
        while (!chosen) begin
          at = hand_pos;
          if (frame_ref[at]) frame_ref[at] = 1'b0;
          else if (frame_dirty[at]) frame_dirty[at] = 1'b0;
          else chosen = 1'b1;
          hand_pos = (at + 1 >= n) ? 0 : at + 1;
        end
      end
      if (frame_live[at]) begin
        r.ev_valid = 1'b1;
        r.ev_page = frame_tag[at];
      end
      frame_tag[at] = page;
      frame_live[at] = 1'b1;
      frame_ref[at] = 1'b1;
      frame_dirty[at] = wr;
      r.frame = at[scpr_pkg::FRAME_INDEX_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRAMES; k++) begin
        frame_tag[k] = '0;
        frame_live[k] = 1'b0;
        frame_ref[k] = 1'b0;
        frame_dirty[k] = 1'b0;
      end
      handed_out = 0;
      hand_pos = 0;
      slots_cfg = 5'd16;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        slots_cfg = cfg_data_i;
        cfg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = resolve_access(s_axis_tdata[PAGE_BITS-1:0], s_axis_tuser[0]);
        if (row_pinned && predicted !== row_want) begin
          note_fault($sformatf("table entry 0x%0h disagrees with model 0x%0h",
                               row_want, predicted));
        end
        pending_results.push_back(row_pinned ? row_want : predicted);
        accesses++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          note_fault("result transaction with no access outstanding");
        end else begin
          oldest = pending_results.pop_front();
          if (oldest.hit) hits++;
          if (oldest.ev_valid) evictions++;
          check_field("hit", m_axis_tuser[0], oldest.hit);
          check_field("used_free_frame", m_axis_tuser[1], oldest.fresh);
          check_field("evicted_valid", m_axis_tuser[2], oldest.ev_valid);
          check_field("frame_index", m_axis_tdata[3:0], oldest.frame);
          check_field("evicted_page", m_axis_tdata[4 +: PAGE_BITS], oldest.ev_page);
          check_field("tdata padding", m_axis_tdata[TDATA_OUT_W-1:4+PAGE_BITS], 0);
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_go && !long_hold_done) begin
        m_axis_tready <= 1'b0;
        for (hold_count = 0; hold_count < LONG_HOLD_CYCLES; hold_count++) @(negedge clk_i);
        long_hold_done = 1'b1;
      end
      m_axis_tready <= steady_run || ($urandom_range(99) >= 35);
    end
  end

  task automatic offer_access(input logic [PAGE_BITS-1:0] page, input logic wr,
                              input logic pinned, input access_result_t want);
    row_pinned = pinned;
    row_want = want;
    if (!steady_run) begin
      while ($urandom_range(99) < 35) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= page;
    s_axis_tuser <= wr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_slots(input logic [scpr_pkg::CFG_W-1:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PAGE_BITS-1:0] pick_page(input int n);
    int          r;
    logic [31:0] rnd;
    r = $urandom_range(99);
    rnd = $urandom;
    if (r < 45) return page_pool[$urandom_range(n - 1)];
    if (r < 85) return page_pool[$urandom_range(2 * n + 1)];
    if (r < 95) return rnd[PAGE_BITS-1:0];
    return rnd[0] ? {PAGE_BITS{1'b1}} : {PAGE_BITS{1'b0}};
  endfunction

  initial begin
    int          n;
    logic [31:0] rnd;
    directed_rows = '{
      '{ROW_ACCESS, 16'h0000, 1'b0, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b1, 1'b0, 16'h0}},
      '{ROW_ACCESS, 16'hFFFF, 1'b1, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b1, 1'b0, 16'h0}},
      '{ROW_ACCESS, 16'h0000, 1'b1, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 1'b0, 16'h0}},
      '{ROW_ACCESS, 16'hFFFF, 1'b0, 5'd0,  1'b1, '{1'b1, 4'd1, 1'b0, 1'b0, 16'h0}},
      '{ROW_CONFIG, 16'h0000, 1'b0, 5'd2,  1'b0, '0},
      '{ROW_ACCESS, 16'h1234, 1'b0, 5'd0,  1'b0, '0},
      '{ROW_ACCESS, 16'h5678, 1'b1, 5'd0,  1'b0, '0},
      '{ROW_ACCESS, 16'h1234, 1'b1, 5'd0,  1'b0, '0},
      '{ROW_ACCESS, 16'h5678, 1'b0, 5'd0,  1'b0, '0},
      '{ROW_CONFIG, 16'h0000, 1'b0, 5'd0,  1'b0, '0},
      '{ROW_ACCESS, 16'h5678, 1'b1, 5'd0,  1'b0, '0},
      '{ROW_CONFIG, 16'h0000, 1'b0, 5'd31, 1'b0, '0},
      '{ROW_ACCESS, 16'h5678, 1'b0, 5'd0,  1'b0, '0},
      '{ROW_ACCESS, 16'h8001, 1'b1, 5'd0,  1'b0, '0},
      '{ROW_ACCESS, 16'h7FFE, 1'b0, 5'd0,  1'b0, '0},
      '{ROW_CONFIG, 16'h0000, 1'b0, 5'd3,  1'b0, '0},
      '{ROW_ACCESS, 16'h0002, 1'b1, 5'd0,  1'b0, '0},
      '{ROW_ACCESS, 16'h0003, 1'b0, 5'd0,  1'b0, '0},
      '{ROW_ACCESS, 16'h0004, 1'b1, 5'd0,  1'b0, '0},
      '{ROW_CONFIG, 16'h0000, 1'b0, 5'd16, 1'b0, '0}
    };
    phase_slots = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd7, 5'd16, 5'd2, 5'd12, 5'd17, 5'd3,
                    5'd16};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CONFIG) begin
        write_slots(directed_rows[r].slots);
      end else begin
        offer_access(directed_rows[r].page, directed_rows[r].wr, directed_rows[r].pinned,
                     directed_rows[r].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_slots(phase_slots[p]);
      n = clamp_slots(phase_slots[p]);
      for (int k = 0; k < 2 * FRAMES + 2; k++) begin
        rnd = $urandom;
        page_pool[k] = rnd[PAGE_BITS-1:0];
      end
      steady_run = (p == 0);
      if (p == HOLD_PHASE) long_hold_go = 1'b1;
      for (int a = 0; a < PHASE_ACCESSES; a++) begin
        if ((p == 5 || p == 9) && a == PHASE_ACCESSES / 2) drain_results();
        offer_access(pick_page(n), $urandom_range(1), 1'b0, '0);
      end
    end
    drain_results();

    $display("Covered %0d accesses: %0d hits, %0d faults, %0d evictions.",
             accesses, hits, accesses - hits, evictions);
    $display("Frame count was rewritten %0d times, including out-of-range settings.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
